// ----- src/auto_base_number_parser_core_macros.svh -----
// assertion macros for the auto base number parser checker
// no dependencies; included by the checker file only
`ifndef AUTO_BASE_NUMBER_PARSER_CORE_MACROS_SVH
`define AUTO_BASE_NUMBER_PARSER_CORE_MACROS_SVH

// implication checked outside of reset
`define ABNP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside of reset
`define ABNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers the reset cycles
`define ABNP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/abnp_pkg.sv -----
// shared types and constants for the auto base number parser
// no dependencies
package abnp_pkg;

    // accumulator width and the width of the reported value
    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int WIDE_WIDTH  = (VALUE_WIDTH > OUT_WIDTH) ? VALUE_WIDTH : OUT_WIDTH;

    // base codes as reported on the result
    localparam logic [1:0] KIND_BAD = 2'd0;
    localparam logic [1:0] KIND_BIN = 2'd1;
    localparam logic [1:0] KIND_DEC = 2'd2;
    localparam logic [1:0] KIND_HEX = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    // parse phase
    typedef enum logic [1:0] {
        PH_LEAD = 2'b01,
        PH_BODY = 2'b10
    } t_phase;

    // character classification handed to the parse state
    typedef struct packed {
        logic       is_nul;
        logic       is_zero;
        logic       hex_prefix;
        logic       bin_prefix;
        logic       dec_lead;
        logic       digit_ok;
        logic [3:0] digit;
    } t_char_info;

    // one result
    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic                 success;
        logic [1:0]           base_kind;
        logic                 overflowed;
    } t_result;

endpackage

// ----- src/auto_base_number_parser_core.sv -----
// auto base number parser top level: input register, parse state, result register
// depends on abnp_pkg, abnp_char_decode, abnp_parse_state
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------------
//   input    | i_valid / o_stall         | i_char_code
//   output   | o_valid / i_stall         | o_value, o_success, o_base_kind, o_overflowed
//
// one character per cycle unless o_stall holds the input; a request is registered, then parsed.
// a terminator's result passes the input register, then the result register, to reach the outputs.
// reset is synchronous and active low; it clears the parse state and both valids.
// a stalled result blocks only a terminator; other characters keep flowing past it.
module auto_base_number_parser_core
    import abnp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_char_code,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_WIDTH-1:0] o_value,
    output logic                 o_success,
    output logic [1:0]           o_base_kind,
    output logic                 o_overflowed
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_out_valid;
    t_result     r_out;
    logic [1:0]  w_kind;
    t_char_info  w_info;
    t_result     w_result;
    logic        w_step;

    // classify the registered character
    abnp_char_decode u_decode (
        .i_char_code  (r_in_char),
        .i_radix_kind (w_kind),
        .o_info       (w_info)
    );

    // parse state update
    abnp_parse_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_info       (w_info),
        .o_radix_kind (w_kind),
        .o_result     (w_result)
    );

    // a terminator advances only when the result register is free
    assign w_step  = r_in_valid && (!w_info.is_nul || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_char <= i_char_code;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_info.is_nul) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_info.is_nul) begin
            r_out <= w_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value      = r_out.value;
    assign o_success    = r_out.success;
    assign o_base_kind  = r_out.base_kind;
    assign o_overflowed = r_out.overflowed;

endmodule

// ----- src/abnp_char_decode.sv -----
// character classifier: prefix, terminator and digit value for the current base
// depends on abnp_pkg
module abnp_char_decode
    import abnp_pkg::*;
(
    input  logic [7:0]  i_char_code,
    input  logic [1:0]  i_radix_kind,
    output t_char_info  o_info
);

    logic       w_dec;
    logic       w_lo_hex;
    logic       w_up_hex;

    // range checks
    assign w_dec    = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign w_lo_hex = (i_char_code >= CH_LO_A) && (i_char_code <= CH_LO_F);
    assign w_up_hex = (i_char_code >= CH_UP_A) && (i_char_code <= CH_UP_F);

    // digit value by base
    always_comb begin
        o_info            = '0;
        o_info.is_nul     = (i_char_code == CH_NUL);
        o_info.is_zero    = (i_char_code == CH_ZERO);
        o_info.hex_prefix = (i_char_code == CH_LO_X) || (i_char_code == CH_UP_X);
        o_info.bin_prefix = (i_char_code == CH_LO_B) || (i_char_code == CH_UP_B);
        o_info.dec_lead   = (i_char_code >= CH_ONE) && (i_char_code <= CH_NINE);
        case (i_radix_kind)
            KIND_BIN: begin
                o_info.digit_ok = (i_char_code == CH_ZERO) || (i_char_code == CH_ONE);
                o_info.digit    = {3'b000, i_char_code[0]};
            end
            KIND_HEX: begin
                o_info.digit_ok = w_dec || w_lo_hex || w_up_hex;
                if (w_lo_hex) begin
                    o_info.digit = HEX_TEN + 4'(i_char_code - CH_LO_A);
                end else if (w_up_hex) begin
                    o_info.digit = HEX_TEN + 4'(i_char_code - CH_UP_A);
                end else begin
                    o_info.digit = i_char_code[3:0];
                end
            end
            default: begin
                o_info.digit_ok = w_dec;
                o_info.digit    = i_char_code[3:0];
            end
        endcase
    end

endmodule

// ----- src/abnp_parse_state.sv -----
// parse state: phase, base, accumulator and flags, plus the result they imply
// depends on abnp_pkg
module abnp_parse_state
    import abnp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_char_info  i_info,
    output logic [1:0]  o_radix_kind,
    output t_result     o_result
);

    t_phase                  r_phase,    n_phase;
    logic [1:0]              r_kind,     n_kind;
    logic [VALUE_WIDTH-1:0]  r_acc,      n_acc;
    logic                    r_bad,      n_bad;
    logic                    r_ovf,      n_ovf;

    logic [VALUE_WIDTH+3:0]  w_dec_sum;
    logic [WIDE_WIDTH-1:0]   w_acc_wide;

    // times ten plus digit as shift-add, carry bits flag overflow
    assign w_dec_sum = {3'b000, r_acc, 1'b0} + {r_acc, 3'b000}
                     + (VALUE_WIDTH+4)'(i_info.digit);

    // next state for one character
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_acc   = r_acc;
        n_bad   = r_bad;
        n_ovf   = r_ovf;
        if (i_info.is_nul) begin
            n_phase = PH_LEAD;
            n_kind  = KIND_BAD;
            n_acc   = '0;
            n_bad   = 1'b0;
            n_ovf   = 1'b0;
        end else begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (!i_info.is_zero) begin
                        n_phase = PH_BODY;
                        if (i_info.hex_prefix) begin
                            n_kind = KIND_HEX;
                        end else if (i_info.bin_prefix) begin
                            n_kind = KIND_BIN;
                        end else if (i_info.dec_lead) begin
                            n_kind = KIND_DEC;
                            n_acc  = VALUE_WIDTH'(i_info.digit);
                        end else begin
                            n_kind = KIND_BAD;
                            n_bad  = 1'b1;
                        end
                    end
                end
                PH_BODY: begin
                    if (!r_bad) begin
                        if (!i_info.digit_ok) begin
                            n_bad  = 1'b1;
                            n_kind = KIND_BAD;
                        end else begin
                            case (r_kind)
                                KIND_BIN: begin
                                    n_ovf = r_ovf | r_acc[VALUE_WIDTH-1];
                                    n_acc = {r_acc[VALUE_WIDTH-2:0], i_info.digit[0]};
                                end
                                KIND_HEX: begin
                                    n_ovf = r_ovf | (|r_acc[VALUE_WIDTH-1:VALUE_WIDTH-4]);
                                    n_acc = {r_acc[VALUE_WIDTH-5:0], i_info.digit};
                                end
                                default: begin
                                    n_ovf = r_ovf | (|w_dec_sum[VALUE_WIDTH+3:VALUE_WIDTH]);
                                    n_acc = w_dec_sum[VALUE_WIDTH-1:0];
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    n_phase = PH_LEAD;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_kind  <= KIND_BAD;
            r_acc   <= '0;
            r_bad   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_acc   <= n_acc;
            r_bad   <= n_bad;
            r_ovf   <= n_ovf;
        end
    end

    assign o_radix_kind = r_kind;
    assign w_acc_wide   = WIDE_WIDTH'(r_acc);

    // result seen by a terminator in the current state
    always_comb begin
        o_result = '0;
        if (r_phase == PH_LEAD) begin
            o_result.success   = 1'b1;
            o_result.base_kind = KIND_DEC;
        end else if (!r_bad) begin
            o_result.value      = w_acc_wide[OUT_WIDTH-1:0];
            o_result.success    = 1'b1;
            o_result.base_kind  = r_kind;
            o_result.overflowed = r_ovf;
        end
    end

endmodule

// ----- src/abnp_checker.sv -----
// port-level checker for the auto base number parser, bound to the top level
// depends on abnp_pkg and auto_base_number_parser_core_macros.svh
`include "auto_base_number_parser_core_macros.svh"

module abnp_checker
    import abnp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_stall,
    input  logic                 o_valid,
    input  logic [OUT_WIDTH-1:0] o_value,
    input  logic                 o_success,
    input  logic [1:0]           o_base_kind,
    input  logic                 o_overflowed
);

    // no result survives a reset
    `ABNP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_valid, "result valid after reset")

    // a failed parse reports zero, invalid base and no overflow
    `ABNP_ASSERT_IMPL(a_fail_clean, i_clk, i_rst_n, o_valid && !o_success, (o_value == '0) && (o_base_kind == KIND_BAD) && !o_overflowed, "failed result not cleared")

    // a successful parse names a real base
    `ABNP_ASSERT_IMPL(a_ok_kind, i_clk, i_rst_n, o_valid && o_success, o_base_kind != KIND_BAD, "successful result with invalid base")

    // a stalled result holds
    `ABNP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_value) && $stable(o_base_kind), "stalled result changed")

endmodule

bind auto_base_number_parser_core abnp_checker u_abnp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_stall      (i_stall),
    .o_valid      (o_valid),
    .o_value      (o_value),
    .o_success    (o_success),
    .o_base_kind  (o_base_kind),
    .o_overflowed (o_overflowed)
);
